// File: hw/rtl/hpi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpi_pkg
// Shared types, codes and arithmetic helpers of the half-pel interpolator.
// ----------------------------------------------------------------------------
package hpi_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    localparam int COORD_W   = 9;
    localparam int PIXEL_W   = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 9;
    localparam int SUM_W     = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Request codes.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [2:0] LAST_TAP = 3'd5;

    localparam logic signed [SUM_W-1:0] ROUND_BIAS = 16'sd16;
    localparam logic signed [SUM_W-1:0] CLIP_LIMIT = 16'sd8192;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_DRAIN,
        ST_RESULT
    } hpi_state_t;

    typedef struct packed {
        logic       capture;
        logic       mem_write;
        logic       rd_en;
        logic [2:0] k;
        logic [2:0] j;
        logic       k_last;
        logic       j_last;
        logic       out_load;
    } hpi_cmd_t;

    typedef struct packed {
        logic is_write;
        logic wr_in_frame;
        logic out_of_frame;
        logic single_tap;
        logic diag;
        logic done;
    } hpi_status_t;

    // Product of one filter tap with an 8-bit value. A plain source pixel is
    // passed through the same path with a gain of 32, which the rounding
    // step divides back out exactly.
    function automatic logic signed [SUM_W-1:0] tap_mul(
        input logic [2:0]         idx,
        input logic               copy,
        input logic [PIXEL_W-1:0] v
    );
        logic signed [SUM_W-1:0] sv;
        logic signed [SUM_W-1:0] res;
        sv = $signed({{(SUM_W-PIXEL_W){1'b0}}, v});
        if (copy)
        begin
            res = sv <<< 5;
        end
        else
        begin
            case (idx)
                3'd0, 3'd5: res = sv;
                3'd1, 3'd4: res = -((sv <<< 2) + sv);
                3'd2, 3'd3: res = (sv <<< 4) + (sv <<< 2);
                default:    res = '0;
            endcase
        end
        return res;
    endfunction

    function automatic logic [PIXEL_W-1:0] round_clip(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] r;
        logic [PIXEL_W-1:0]      res;
        r = s + ROUND_BIAS;
        if (r < 0)
        begin
            res = '0;
        end
        else if (r >= CLIP_LIMIT)
        begin
            res = '1;
        end
        else
        begin
            res = r[PIXEL_W+4:5];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/hpi_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpi_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module hpi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// File: hw/rtl/hpi_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpi_ctrl
// Sequencer: accepts requests, steps the tap and row counters of a read and
// hands finished results to the output register.
// ----------------------------------------------------------------------------
module hpi_ctrl
    import hpi_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  wire hpi_status_t stat,
    output hpi_cmd_t         ctl
);

    hpi_state_t state_reg, state_next;
    logic [2:0] k_reg, k_next;
    logic [2:0] j_reg, j_next;
    logic       out_valid_reg, out_valid_next;
    logic       k_last;
    logic       j_last;
    logic       slot_free;

    assign k_last    = (k_reg == (stat.single_tap ? 3'd0 : LAST_TAP));
    assign j_last    = !stat.diag || (j_reg == LAST_TAP);
    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (stat.is_write)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.out_of_frame)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (k_last && j_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (stat.done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        k_next = k_reg;
        j_next = j_reg;
        if (state_reg == ST_DECODE)
        begin
            k_next = '0;
            j_next = '0;
        end
        else if (state_reg == ST_READ)
        begin
            if (k_last)
            begin
                k_next = '0;
                j_next = j_reg + 3'd1;
            end
            else
            begin
                k_next = k_reg + 3'd1;
            end
        end
    end

    always_comb
    begin
        in_ready      = 1'b0;
        ctl.capture   = 1'b0;
        ctl.mem_write = 1'b0;
        ctl.rd_en     = 1'b0;
        ctl.k         = k_reg;
        ctl.j         = j_reg;
        ctl.k_last    = k_last;
        ctl.j_last    = j_last;
        ctl.out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                ctl.capture = in_valid;
            end
            ST_DECODE: ctl.mem_write = stat.is_write && stat.wr_in_frame;
            ST_READ:   ctl.rd_en     = 1'b1;
            ST_RESULT: ctl.out_load  = slot_free;
            default:   ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A waiting result is never overwritten.
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> (!out_valid_reg || out_ready))
        else $error("result loaded over a result still waiting");

    // The datapath reports a finished sample only while the sequencer waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> (state_reg == ST_DRAIN))
        else $error("datapath done outside of drain");

    // An accepted request is decoded in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_DECODE))
        else $error("accepted request not decoded");

    // Tap and row counters stay inside the six-tap window during a read.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (k_reg <= LAST_TAP && j_reg <= LAST_TAP))
        else $error("tap counter out of range");

endmodule
`default_nettype wire

// File: hw/rtl/hpi_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hpi_datapath
// Frame store, coordinate clamping, filter accumulators and result registers.
// ----------------------------------------------------------------------------
module hpi_datapath
    import hpi_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 cmd,
    input  wire logic [COORD_W-1:0]   col,
    input  wire logic [COORD_W-1:0]   row,
    input  wire logic [PIXEL_W-1:0]   pixel,
    input  wire hpi_cmd_t             ctl,
    output hpi_status_t               stat,
    output logic [PIXEL_W-1:0]        sample,
    output logic                      status
);

    localparam int DEPTH    = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CFG_MAX  = (1 << CFG_W) - 1;
    localparam int W_LIMIT  = (MAX_WIDTH > CFG_MAX) ? CFG_MAX : MAX_WIDTH;
    localparam int H_LIMIT  = (MAX_HEIGHT > CFG_MAX) ? CFG_MAX : MAX_HEIGHT;
    localparam int W_RESET  = (W_LIMIT > 256) ? 256 : W_LIMIT;
    localparam int H_RESET  = (H_LIMIT > 256) ? 256 : H_LIMIT;
    localparam logic [ADDR_W-1:0] ROW_PITCH = ADDR_W'(MAX_WIDTH);

    function automatic logic [CFG_W-1:0] clamp_cfg(
        input logic [CFG_W-1:0] v,
        input logic [CFG_W-1:0] lim
    );
        logic [CFG_W-1:0] res;
        if (v == '0)
        begin
            res = CFG_W'(1);
        end
        else if (v > lim)
        begin
            res = lim;
        end
        else
        begin
            res = v;
        end
        return res;
    endfunction

    // Source coordinate base+off-2, held inside 0..n-1.
    function automatic logic [COORD_W-1:0] clamp_coord(
        input logic [COORD_W-2:0] base,
        input logic [2:0]         off,
        input logic [CFG_W-1:0]   n
    );
        logic signed [COORD_W+1:0] v;
        logic [COORD_W-1:0]        res;
        v = (COORD_W+2)'($signed({3'b000, base}) + $signed({{(COORD_W-1){1'b0}}, off}) - 2);
        if (v < 0)
        begin
            res = '0;
        end
        else if (v >= $signed({2'b00, n}))
        begin
            res = n - CFG_W'(1);
        end
        else
        begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic               cmd_reg;
    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] row_reg;
    logic [PIXEL_W-1:0] pixel_reg;

    logic [COORD_W-2:0] half_x;
    logic [COORD_W-2:0] half_y;
    logic               copy_mode;
    logic               diag_mode;
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [ADDR_W-1:0]  addr;
    logic [PIXEL_W-1:0] rdata;

    logic       s1_valid_reg, s1_valid_next;
    logic [2:0] s1_k_reg;
    logic       s1_klast_reg;
    logic [2:0] s1_j_reg;
    logic       s1_jlast_reg;
    logic       s2_valid_reg, s2_valid_next;
    logic [2:0] s2_j_reg;
    logic       s2_jlast_reg;
    logic       s3_valid_reg, s3_valid_next;
    logic       done_reg, done_next;

    logic signed [SUM_W-1:0] inner_reg, inner_next;
    logic signed [SUM_W-1:0] outer_reg, outer_next;
    logic [PIXEL_W-1:0]      half_val;
    logic [PIXEL_W-1:0]      result_reg;
    logic [PIXEL_W-1:0]      out_sample_reg;
    logic                    out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_W'(W_RESET);
            height_reg <= CFG_W'(H_RESET);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= clamp_cfg(cfg_data, CFG_W'(W_LIMIT));
                REG_FRAME_HEIGHT: height_reg <= clamp_cfg(cfg_data, CFG_W'(H_LIMIT));
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg   <= cmd;
            col_reg   <= col;
            row_reg   <= row;
            pixel_reg <= pixel;
        end
    end

    assign half_x    = col_reg[COORD_W-1:1];
    assign half_y    = row_reg[COORD_W-1:1];
    assign copy_mode = !col_reg[0] && !row_reg[0];
    assign diag_mode = col_reg[0] && row_reg[0];

    assign stat.is_write     = (cmd_reg == CMD_WRITE);
    assign stat.wr_in_frame  = (col_reg < width_reg) && (row_reg < height_reg);
    assign stat.out_of_frame = ({1'b0, col_reg} >= {width_reg, 1'b0})
                            || ({1'b0, row_reg} >= {height_reg, 1'b0});
    assign stat.single_tap   = copy_mode;
    assign stat.diag         = diag_mode;
    assign stat.done         = done_reg;

    // Horizontal taps walk x, vertical taps walk y; a diagonal read walks x
    // within a row and steps the row once per six taps.
    always_comb
    begin
        if (cmd_reg == CMD_WRITE)
        begin
            src_x = col_reg;
            src_y = row_reg;
        end
        else
        begin
            src_x = col_reg[0] ? clamp_coord(half_x, ctl.k, width_reg) : {1'b0, half_x};
            if (diag_mode)
            begin
                src_y = clamp_coord(half_y, ctl.j, height_reg);
            end
            else if (row_reg[0])
            begin
                src_y = clamp_coord(half_y, ctl.k, height_reg);
            end
            else
            begin
                src_y = {1'b0, half_y};
            end
        end
    end

    assign addr = ADDR_W'(src_y) * ROW_PITCH + ADDR_W'(src_x);

    hpi_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk   (clk),
        .we    (ctl.mem_write),
        .addr  (addr),
        .wdata (pixel_reg),
        .rdata (rdata)
    );

    assign inner_next    = ((s1_k_reg == 3'd0) ? '0 : inner_reg)
                         + tap_mul(s1_k_reg, copy_mode, rdata);
    assign half_val      = round_clip(inner_reg);
    assign outer_next    = ((s2_j_reg == 3'd0) ? '0 : outer_reg)
                         + tap_mul(s2_j_reg, 1'b0, half_val);
    assign s1_valid_next = ctl.rd_en;
    assign s2_valid_next = s1_valid_reg && s1_klast_reg;
    assign s3_valid_next = s2_valid_reg && diag_mode && s2_jlast_reg;
    assign done_next     = (s2_valid_reg && !diag_mode) || s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_k_reg     <= ctl.k;
        s1_klast_reg <= ctl.k_last;
        s1_j_reg     <= ctl.j;
        s1_jlast_reg <= ctl.j_last;
        if (s1_valid_reg)
        begin
            inner_reg <= inner_next;
        end
        if (s2_valid_next)
        begin
            s2_j_reg     <= s1_j_reg;
            s2_jlast_reg <= s1_jlast_reg;
        end
        if (s2_valid_reg)
        begin
            if (diag_mode)
            begin
                outer_reg <= outer_next;
            end
            else
            begin
                result_reg <= half_val;
            end
        end
        if (s3_valid_reg)
        begin
            result_reg <= round_clip(outer_reg);
        end
        if (ctl.out_load)
        begin
            out_sample_reg <= stat.out_of_frame ? '0 : result_reg;
            out_status_reg <= stat.out_of_frame;
        end
    end

    assign sample = out_sample_reg;
    assign status = out_status_reg;

endmodule
`default_nettype wire

// File: hw/rtl/half_pel_six_tap_interpolator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// half_pel_six_tap_interpolator_core
// Frame store with six-tap half-pel interpolation on read requests.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Payload
//  -------   ---------------------   ---------------------------------
//  input     in_valid / in_ready     cmd, col, row, pixel
//  output    out_valid / out_ready   sample, status
//  config    cfg_write_en            cfg_index, cfg_data
//
//  One request at a time. A read issues one frame store access per cycle on
//  the single RAM port: 1, 6 or 36 accesses for full-pel, one-axis and
//  diagonal positions, after decode and ahead of the filter pipeline and
//  result hand-off. Reset is asynchronous and clears control state only;
//  the frame store is not cleared. A stalled output holds its result while
//  the next request is accepted and processed.
//
module half_pel_six_tap_interpolator_core
    import hpi_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 cmd,
    input  wire logic [COORD_W-1:0]   col,
    input  wire logic [COORD_W-1:0]   row,
    input  wire logic [PIXEL_W-1:0]   pixel,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [PIXEL_W-1:0]        sample,
    output logic                      status,
    input  wire logic                 cfg_write_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    hpi_cmd_t    ctl;
    hpi_status_t stat;

    hpi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    hpi_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .col          (col),
        .row          (row),
        .pixel        (pixel),
        .ctl          (ctl),
        .stat         (stat),
        .sample       (sample),
        .status       (status)
    );

endmodule
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the half-pel six-tap interpolator core. A shadow
// frame and a bit-exact filter predict every read sample. Each reaching read
// is preceded by writes of any neighbor pixel not yet stored. Runs cover
// frame sizes down to a single pixel and up to the maximum, out-of-frame
// requests, and idle and stall phases on both channels, plus a long output
// hold-off.
// ----------------------------------------------------------------------------
module tb;
    import hpi_pkg::*;

    localparam int GRID_STRIDE  = 256;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [PIXEL_W-1:0] sample;
        logic               status;
    } hp_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 req_cmd = CMD_WRITE;
    logic [COORD_W-1:0]   req_col = '0;
    logic [COORD_W-1:0]   req_row = '0;
    logic [PIXEL_W-1:0]   req_pixel = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [PIXEL_W-1:0]   res_sample;
    logic                 res_status;
    logic                 cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Shadow of the frame store and of the two size registers.
    logic [PIXEL_W-1:0] shadow_frame [0:GRID_STRIDE*GRID_STRIDE-1];
    bit                 pixel_written [0:GRID_STRIDE*GRID_STRIDE-1];
    int                 frame_w = 256;
    int                 frame_h = 256;

    hp_result_t expected_q [$];

    int sender_idle_pct = 0;
    int ready_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;

    int items_sent = 0;
    int reads_checked = 0;
    int frame_settings = 0;
    int fail_count = 0;

    half_pel_six_tap_interpolator_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (req_cmd),
        .col          (req_col),
        .row          (req_row),
        .pixel        (req_pixel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample       (res_sample),
        .status       (res_status),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Interpolation predictor
    // ------------------------------------------------------------------
    function automatic int held_size(input logic [CFG_W-1:0] v, input int hi);
        if (v == 0)
        begin
            return 1;
        end
        if (int'(v) > hi)
        begin
            return hi;
        end
        return int'(v);
    endfunction

    function automatic int clamp_axis(input int v, input int n);
        if (v < 0)
        begin
            return 0;
        end
        if (v >= n)
        begin
            return n - 1;
        end
        return v;
    endfunction

    function automatic int tap_weight(input int k);
        case (k)
            0, 5: return 1;
            1, 4: return -5;
            default: return 20;
        endcase
    endfunction

    function automatic logic [PIXEL_W-1:0] round_to_pixel(input int sum);
        int r;
        r = sum + 16;
        if (r < 0)
        begin
            return '0;
        end
        r = r >>> 5;
        if (r > 255)
        begin
            return 8'hFF;
        end
        return r[PIXEL_W-1:0];
    endfunction

    function automatic int src_pixel(input int x, input int y);
        return int'(shadow_frame[y * GRID_STRIDE + x]);
    endfunction

    function automatic logic [PIXEL_W-1:0] horiz_half_pel(input int x, input int y);
        int acc;
        acc = 0;
        for (int k = 0; k < 6; k++)
        begin
            acc += tap_weight(k) * src_pixel(clamp_axis(x + k - 2, frame_w), y);
        end
        return round_to_pixel(acc);
    endfunction

    function automatic logic [PIXEL_W-1:0] vert_half_pel(input int x, input int y);
        int acc;
        acc = 0;
        for (int k = 0; k < 6; k++)
        begin
            acc += tap_weight(k) * src_pixel(x, clamp_axis(y + k - 2, frame_h));
        end
        return round_to_pixel(acc);
    endfunction

    // The diagonal filters six already clipped horizontal half-pel values.
    function automatic logic [PIXEL_W-1:0] diag_half_pel(input int x, input int y);
        int acc;
        acc = 0;
        for (int k = 0; k < 6; k++)
        begin
            acc += tap_weight(k) * int'(horiz_half_pel(x, clamp_axis(y + k - 2, frame_h)));
        end
        return round_to_pixel(acc);
    endfunction

    function automatic hp_result_t predict_sample(input int col, input int row);
        hp_result_t r;
        int x;
        int y;
        x = col >> 1;
        y = row >> 1;
        r.status = 1'b0;
        if (col >= 2 * frame_w || row >= 2 * frame_h)
        begin
            r.sample = '0;
            r.status = 1'b1;
        end
        else if (col[0] == 1'b0 && row[0] == 1'b0)
        begin
            r.sample = shadow_frame[y * GRID_STRIDE + x];
        end
        else if (row[0] == 1'b0)
        begin
            r.sample = horiz_half_pel(x, y);
        end
        else if (col[0] == 1'b0)
        begin
            r.sample = vert_half_pel(x, y);
        end
        else
        begin
            r.sample = diag_half_pel(x, y);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    function automatic logic [PIXEL_W-1:0] pick_pixel();
        int r;
        r = $urandom_range(9);
        if (r < 2)
        begin
            return 8'h00;
        end
        if (r < 4)
        begin
            return 8'hFF;
        end
        return PIXEL_W'($urandom_range(255));
    endfunction

    task automatic send_request(input logic c, input int col, input int row,
                                input logic [PIXEL_W-1:0] px);
        int gap;
        gap = 0;
        if ($urandom_range(99) < sender_idle_pct)
        begin
            gap = $urandom_range(4, 1);
        end
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_cmd   = c;
        req_col   = COORD_W'(col);
        req_row   = COORD_W'(row);
        req_pixel = px;
        in_valid  = 1'b1;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        if (c == CMD_WRITE)
        begin
            if (col < frame_w && row < frame_h)
            begin
                shadow_frame[row * GRID_STRIDE + col] = px;
                pixel_written[row * GRID_STRIDE + col] = 1'b1;
            end
        end
        else
        begin
            expected_q.push_back(predict_sample(col, row));
        end
    endtask

    // Stores any pixel the read would touch that has never been written,
    // then issues the read itself.
    task automatic read_sample(input int col, input int row);
        int x_lo;
        int x_hi;
        int y_lo;
        int y_hi;
        if (col < 2 * frame_w && row < 2 * frame_h)
        begin
            x_lo = col >> 1;
            x_hi = x_lo;
            y_lo = row >> 1;
            y_hi = y_lo;
            if (col[0])
            begin
                x_lo = clamp_axis(x_lo - 2, frame_w);
                x_hi = clamp_axis(x_hi + 3, frame_w);
            end
            if (row[0])
            begin
                y_lo = clamp_axis(y_lo - 2, frame_h);
                y_hi = clamp_axis(y_hi + 3, frame_h);
            end
            for (int yy = y_lo; yy <= y_hi; yy++)
            begin
                for (int xx = x_lo; xx <= x_hi; xx++)
                begin
                    if (!pixel_written[yy * GRID_STRIDE + xx])
                    begin
                        send_request(CMD_WRITE, xx, yy, pick_pixel());
                    end
                end
            end
        end
        send_request(CMD_READ, col, row, PIXEL_W'($urandom_range(255)));
    endtask

    // Waits until every read has been answered and the last write retired.
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        @(negedge clk);
        cfg_write_en = 1'b1;
        cfg_index    = idx;
        cfg_data     = CFG_W'(data);
        if (idx == REG_FRAME_WIDTH)
        begin
            frame_w = held_size(CFG_W'(data), DEF_MAX_WIDTH);
        end
        else
        begin
            frame_h = held_size(CFG_W'(data), DEF_MAX_HEIGHT);
        end
        @(negedge clk);
        cfg_write_en = 1'b0;
    endtask

    task automatic set_frame(input int w_data, input int h_data);
        wait_drained();
        write_reg(REG_FRAME_WIDTH, w_data);
        write_reg(REG_FRAME_HEIGHT, h_data);
        frame_settings++;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready = 1'b0;
            hold_left--;
        end
        else if (hold_request > 0)
        begin
            out_ready = 1'b0;
            hold_left = hold_request - 1;
            hold_request = 0;
        end
        else
        begin
            out_ready = ($urandom_range(99) >= ready_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_result
        hp_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                begin
                    $display("[%0t] result with no read pending: sample %0d status %0d",
                             $time, res_sample, res_status);
                end
            end
            else
            begin
                want = expected_q.pop_front();
                reads_checked++;
                if (want.sample !== res_sample || want.status !== res_status)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $display("[%0t] mismatch: sample exp %0d got %0d, status exp %0d got %0d",
                                 $time, want.sample, res_sample, want.status, res_status);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zero sizes are held as one: every grid parity collapses to the single
    // pixel, writes beyond it are dropped, and reads beyond the grid flag.
    task automatic test_tiny_frame();
        set_frame(0, 0);
        send_request(CMD_WRITE, 0, 0, 8'hFF);
        send_request(CMD_WRITE, 1, 0, 8'h07);
        send_request(CMD_WRITE, 0, 1, 8'h09);
        send_request(CMD_WRITE, 511, 511, 8'h00);
        read_sample(0, 0);
        read_sample(1, 0);
        read_sample(0, 1);
        read_sample(1, 1);
        read_sample(2, 0);
        read_sample(0, 2);
        read_sample(511, 511);
        send_request(CMD_WRITE, 0, 0, 8'h00);
        read_sample(1, 1);
    endtask

    // Sizes above the maximum are held at the maximum; the far corner of the
    // doubled grid is then still inside the frame.
    task automatic test_register_limits();
        set_frame(511, 300);
        read_sample(511, 511);
        read_sample(510, 510);
        read_sample(511, 510);
        read_sample(510, 511);
    endtask

    // The receiver holds off while reads keep coming, so the block fills up
    // and must stall its input until the hold-off ends.
    task automatic test_backpressure();
        set_frame(8, 8);
        sender_idle_pct = 0;
        ready_stall_pct = 0;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 24; i++)
        begin
            read_sample($urandom_range(15), $urandom_range(15));
        end
        while (hold_request != 0 || hold_left != 0) @(negedge clk);
    endtask

    function automatic int pick_coord(input int n, input int window_base);
        int r;
        r = $urandom_range(9);
        if (n > 16 && r < 6)
        begin
            return window_base + $urandom_range(31);
        end
        if (r == 6)
        begin
            return 0;
        end
        if (r == 7)
        begin
            return 2 * n - 1;
        end
        if (r == 8 && 2 * n <= 511)
        begin
            return 2 * n;
        end
        return $urandom_range(2 * n - 1);
    endfunction

    task automatic run_phase(input int w_data, input int h_data, input int s_pct,
                             input int r_pct, input int budget);
        int start;
        int pick;
        int base_x;
        int base_y;
        set_frame(w_data, h_data);
        sender_idle_pct = s_pct;
        ready_stall_pct = r_pct;
        base_x = (frame_w > 16) ? $urandom_range(2 * frame_w - 32) : 0;
        base_y = (frame_h > 16) ? $urandom_range(2 * frame_h - 32) : 0;
        start = items_sent;
        while (items_sent - start < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
            begin
                send_request(CMD_WRITE, $urandom_range(511), $urandom_range(511),
                             pick_pixel());
            end
            else if (pick < 15)
            begin
                send_request(CMD_WRITE, $urandom_range(frame_w), $urandom_range(frame_h),
                             pick_pixel());
            end
            else if (pick < 20)
            begin
                read_sample($urandom_range(511), $urandom_range(511));
            end
            else
            begin
                read_sample(pick_coord(frame_w, base_x), pick_coord(frame_h, base_y));
            end
        end
    endtask

    task automatic test_random_traffic();
        run_phase(8, 8, 0, 0, 110);
        run_phase(16, 4, 55, 0, 110);
        run_phase(4, 16, 0, 55, 110);
        run_phase(1, 256, 11, 11, 110);
        run_phase(256, 1, 0, 0, 110);
        run_phase(256, 256, 11, 11, 160);
        run_phase(3, 5, 55, 0, 100);
        run_phase($urandom_range(20, 1), $urandom_range(20, 1), 0, 55, 100);
        run_phase(2, 2, 11, 11, 100);
        run_phase(0, 511, 55, 55, 70);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_tiny_frame();
        test_register_limits();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        $display("Sent %0d requests over %0d frame settings; %0d read samples checked.",
                 items_sent, frame_settings, reads_checked);
        $display("Phases ran with and without idle and stall, plus one long output hold-off;"
                 , " %0d failures.", fail_count);
        if (fail_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("Timed out with %0d reads still pending.", expected_q.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
